// ===== sv/datt_pkg.sv =====
package datt_pkg;

    typedef enum logic [2:0] {
        KIND_START_DAEMON = 3'd0,
        KIND_KILL         = 3'd1,
        KIND_START_FUSE   = 3'd2,
        KIND_LENGTHEN     = 3'd3,
        KIND_RUN_DAEMONS  = 3'd4,
        KIND_RUN_FUSES    = 3'd5
    } kind_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic signed [15:0] DAEMON_TIME = -16'sd1;

    // Most entries that may fire in one run command.
    localparam int MAX_RESULTS = 32;

    // One slot's contents as it travels around the ring.
    typedef struct packed {
        logic [1:0]         phase;
        logic [7:0]         action;
        logic [31:0]        argument;
        logic signed [15:0] stime;
    } slot_t;

    // Command broadcast from the controller to the head cell.
    typedef struct packed {
        logic               act;
        logic [2:0]         kind;
        logic [7:0]         action_id;
        logic [31:0]        action_arg;
        logic [1:0]         phase;
        logic signed [15:0] turns;
        logic               done;
    } cmd_t;

    // What the head cell reports for the slot it processed this cycle.
    typedef struct packed {
        logic        hit;
        logic        fired;
        logic [7:0]  fired_id;
        logic [31:0] fired_arg;
    } rep_t;

endpackage

// ===== sv/datt_cell.sv =====
// One storage cell of the ring: holds a slot and hands it to its neighbor
// whenever the ring rotates.
module datt_cell
    import datt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  shift,
    input  slot_t slot_in,
    output slot_t slot_out
);

    logic [1:0] phase_reg;
    logic [7:0] action_reg;
    logic [31:0] argument_reg;
    logic signed [15:0] stime_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else if (shift)
        begin
            phase_reg <= slot_in.phase;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            action_reg   <= slot_in.action;
            argument_reg <= slot_in.argument;
            stime_reg    <= slot_in.stime;
        end
    end

    assign slot_out = '{phase: phase_reg, action: action_reg,
                        argument: argument_reg, stime: stime_reg};

endmodule

// ===== sv/datt_head.sv =====
// Head of the ring: applies the current command to the slot that leaves the
// last cell and returns the updated slot to the first cell.
module datt_head
    import datt_pkg::*;
(
    input  cmd_t  cmd,
    input  slot_t slot_in,
    output slot_t slot_out,
    output rep_t  rep
);

    logic               used;
    logic signed [16:0] sum;
    logic signed [15:0] dec;

    always_comb
    begin
        used     = (slot_in.phase != 2'd0);
        sum      = 17'(slot_in.stime) + 17'(cmd.turns);
        dec      = slot_in.stime - 16'sd1;
        slot_out = slot_in;
        rep      = '0;
        if (cmd.act)
        begin
            case (cmd.kind)
                KIND_START_DAEMON, KIND_START_FUSE:
                begin
                    if (!cmd.done && !used)
                    begin
                        rep.hit = 1'b1;
                        slot_out.phase    = cmd.phase;
                        slot_out.action   = cmd.action_id;
                        slot_out.argument = cmd.action_arg;
                        slot_out.stime    = (cmd.kind == KIND_START_DAEMON)
                                            ? DAEMON_TIME : cmd.turns;
                    end
                end
                KIND_KILL:
                begin
                    if (!cmd.done && used && slot_in.action == cmd.action_id)
                    begin
                        rep.hit = 1'b1;
                        slot_out.phase = 2'd0;
                    end
                end
                KIND_LENGTHEN:
                begin
                    if (!cmd.done && used && slot_in.action == cmd.action_id)
                    begin
                        rep.hit = 1'b1;
                        if (sum > 17'sd32767)
                            slot_out.stime = 16'sd32767;
                        else if (sum < -17'sd32768)
                            slot_out.stime = -16'sd32768;
                        else
                            slot_out.stime = sum[15:0];
                    end
                end
                KIND_RUN_DAEMONS:
                begin
                    if (!cmd.done && used && slot_in.phase == cmd.phase
                        && slot_in.stime == DAEMON_TIME)
                    begin
                        rep.fired = 1'b1;
                    end
                end
                KIND_RUN_FUSES:
                begin
                    if (!cmd.done && used && slot_in.phase == cmd.phase
                        && slot_in.stime > 16'sd0)
                    begin
                        slot_out.stime = dec;
                        if (dec == 16'sd0)
                        begin
                            slot_out.phase = 2'd0;
                            rep.fired = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        rep.fired_id  = slot_in.action;
        rep.fired_arg = slot_in.argument;
    end

endmodule

// ===== sv/delayed_action_timer_table.sv =====
// Channel | Direction | Payload (lowest bit first)
// s_axis  | in        | tdata: action_id[7:0], action_arg[39:8], phase[41:40],
//         |           |        turns[57:42], zero fill to 64; tuser: kind
// m_axis  | out       | tdata: fired_id[7:0], fired_arg[39:8]; tuser: status;
//         |           | tlast: last
//
// Every command rotates the whole ring of SLOTS cells once, one slot per
// cycle while the ring is not stalled. A command passes through an idle
// state that takes it, the rotation through all SLOTS cells and a final
// state that issues the final result; no new command is taken until idle.
// Reset empties every slot at once through the phase flip-flops.
// A new fired result that meets a pending result and a stalled, full output
// holds the rotation; the ring then waits and nothing is lost.
module delayed_action_timer_table
    import datt_pkg::*;
#(
    parameter int SLOTS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // action_id, action_arg, phase, turns
    input  logic [2:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // fired_id, fired_arg
    output logic [1:0]  m_axis_tuser,   // status
    output logic        m_axis_tlast
);

    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [1:0] { S_IDLE, S_SCAN, S_FINAL } state_t;

    state_t  state_reg;
    cmd_t    cmd_reg;
    logic [CW-1:0] count_reg;
    logic    any_reg;      // a result was produced (fired or hit)
    logic [5:0] nfire_reg; // entries fired so far by the current run command

    // Pending fired result, held back until the next one arrives so that
    // tlast can be set on the final one.
    logic        pend_reg;
    logic [7:0]  pend_id_reg;
    logic [31:0] pend_arg_reg;

    logic        ovalid_reg;
    logic [1:0]  ostat_reg;
    logic [7:0]  oid_reg;
    logic [31:0] oarg_reg;
    logic        olast_reg;

    slot_t ring [SLOTS];
    slot_t head_out;
    rep_t  rep;
    cmd_t  cmd_eff;
    logic  out_free;
    logic  shift;
    logic  out_load;

    assign out_free = !ovalid_reg || m_axis_tready;
    // A fire while a pending result cannot be pushed stalls the ring.
    assign shift = (state_reg == S_SCAN) && !(rep.fired && pend_reg && !out_free);
    // The output register takes a new result this cycle.
    assign out_load = (shift && rep.fired && pend_reg)
                      || (state_reg == S_FINAL && out_free);

    always_comb
    begin
        cmd_eff     = cmd_reg;
        cmd_eff.act = (state_reg == S_SCAN);
    end

    datt_head u_head (
        .cmd      (cmd_eff),
        .slot_in  (ring[SLOTS-1]),
        .slot_out (head_out),
        .rep      (rep)
    );

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            if (g == 0)
            begin : g_first
                datt_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                  .slot_in(head_out), .slot_out(ring[g]));
            end
            else
            begin : g_rest
                datt_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(shift),
                                  .slot_in(ring[g-1]), .slot_out(ring[g]));
            end
        end
    endgenerate

    assign s_axis_tready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            count_reg    <= '0;
            any_reg      <= 1'b0;
            nfire_reg    <= 6'd0;
            pend_reg     <= 1'b0;
            pend_id_reg  <= 8'd0;
            pend_arg_reg <= 32'd0;
            ovalid_reg   <= 1'b0;
            ostat_reg    <= ST_OK;
            oid_reg      <= 8'd0;
            oarg_reg     <= 32'd0;
            olast_reg    <= 1'b0;
        end
        else
        begin
            ovalid_reg <= out_load || (ovalid_reg && !m_axis_tready);
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        cmd_reg.kind       <= s_axis_tuser;
                        cmd_reg.action_id  <= s_axis_tdata[7:0];
                        cmd_reg.action_arg <= s_axis_tdata[39:8];
                        cmd_reg.phase      <= s_axis_tdata[41:40];
                        cmd_reg.turns      <= s_axis_tdata[57:42];
                        cmd_reg.done       <= 1'b0;
                        count_reg <= '0;
                        any_reg   <= 1'b0;
                        nfire_reg <= 6'd0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (shift)
                    begin
                        if (rep.hit)
                        begin
                            cmd_reg.done <= 1'b1;
                            any_reg <= 1'b1;
                        end
                        if (rep.fired)
                        begin
                            any_reg   <= 1'b1;
                            nfire_reg <= nfire_reg + 6'd1;
                            // Once the result cap is reached the rest of the
                            // ring passes untouched.
                            if (nfire_reg == 6'(MAX_RESULTS - 1))
                                cmd_reg.done <= 1'b1;
                            if (pend_reg)
                            begin
                                ostat_reg  <= ST_OK;
                                oid_reg    <= pend_id_reg;
                                oarg_reg   <= pend_arg_reg;
                                olast_reg  <= 1'b0;
                            end
                            pend_reg     <= 1'b1;
                            pend_id_reg  <= rep.fired_id;
                            pend_arg_reg <= rep.fired_arg;
                        end
                        if (count_reg == CW'(SLOTS - 1))
                            state_reg <= S_FINAL;
                        count_reg <= count_reg + 1'b1;
                    end
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        olast_reg  <= 1'b1;
                        state_reg  <= S_IDLE;
                        if (pend_reg)
                        begin
                            ostat_reg <= ST_OK;
                            oid_reg   <= pend_id_reg;
                            oarg_reg  <= pend_arg_reg;
                        end
                        else
                        begin
                            oid_reg  <= 8'd0;
                            oarg_reg <= 32'd0;
                            if (cmd_reg.kind == KIND_START_DAEMON
                                || cmd_reg.kind == KIND_START_FUSE)
                                ostat_reg <= any_reg ? ST_OK : ST_FULL;
                            else if (cmd_reg.kind == KIND_KILL
                                     || cmd_reg.kind == KIND_LENGTHEN)
                                ostat_reg <= any_reg ? ST_OK : ST_NOTFOUND;
                            else
                                ostat_reg <= ST_NONE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {oarg_reg, oid_reg};
    assign m_axis_tuser  = ostat_reg;
    assign m_axis_tlast  = olast_reg;

    // A held result must not change while the consumer stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !m_axis_tready |=> ovalid_reg && $stable(oid_reg))
        else $error("output changed under stall");

    // Only one command in flight: input is never taken during a scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !s_axis_tready)
        else $error("input accepted during scan");

    // A first-match command hits at most once per rotation.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_reg.done && state_reg == S_SCAN |-> !rep.hit)
        else $error("second hit in one command");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import datt_pkg::*;

    localparam int NSLOTS = 32;
    localparam longint CYCLE_LIMIT = 400000;

    // One expected result of the table.
    typedef struct {
        logic [1:0]  status;
        logic [7:0]  fired_id;
        logic [31:0] fired_arg;
        logic        last;
    } timer_result_t;

    // Scoreboard: keeps a private copy of the slot table, predicts the results
    // of every accepted command and checks the results as they leave the block.
    class timer_table_board;
        logic [1:0]         tbl_phase [NSLOTS];
        logic [7:0]         tbl_action [NSLOTS];
        logic [31:0]        tbl_arg [NSLOTS];
        logic signed [15:0] tbl_time [NSLOTS];
        timer_result_t      pending [$];
        int                 errors;

        function new();
            errors = 0;
            foreach (tbl_phase[i])
            begin
                tbl_phase[i] = 2'd0;
                tbl_action[i] = 8'd0;
                tbl_arg[i] = 32'd0;
                tbl_time[i] = 16'sd0;
            end
        endfunction

        function void push(logic [1:0] st, logic [7:0] id, logic [31:0] arg, logic lst);
            timer_result_t r;
            r.status = st;
            r.fired_id = id;
            r.fired_arg = arg;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function int count_live();
            int n;
            n = 0;
            foreach (tbl_phase[i])
                if (tbl_phase[i] != 2'd0)
                    n++;
            return n;
        endfunction

        // Action id of the first live slot; killing it removes exactly that slot.
        function logic [7:0] first_live_action();
            int slot;
            slot = -1;
            foreach (tbl_phase[i])
                if (slot < 0 && tbl_phase[i] != 2'd0)
                    slot = i;
            if (slot < 0)
                return 8'd0;
            return tbl_action[slot];
        endfunction

        // Note one accepted command and queue the results it must produce.
        function void note_command(logic [2:0] kind, logic [7:0] id, logic [31:0] arg,
                                   logic [1:0] ph, logic signed [15:0] turns);
            int slot;
            int n;
            int sum;
            slot = -1;
            n = 0;
            case (kind)
                KIND_START_DAEMON, KIND_START_FUSE:
                begin
                    foreach (tbl_phase[i])
                        if (slot < 0 && tbl_phase[i] == 2'd0)
                            slot = i;
                    if (slot < 0)
                        push(ST_FULL, 8'd0, 32'd0, 1'b1);
                    else
                    begin
                        tbl_phase[slot] = ph;
                        tbl_action[slot] = id;
                        tbl_arg[slot] = arg;
                        tbl_time[slot] = (kind == KIND_START_DAEMON) ? DAEMON_TIME : turns;
                        push(ST_OK, 8'd0, 32'd0, 1'b1);
                    end
                end
                KIND_KILL, KIND_LENGTHEN:
                begin
                    foreach (tbl_phase[i])
                        if (slot < 0 && tbl_phase[i] != 2'd0 && tbl_action[i] == id)
                            slot = i;
                    if (slot < 0)
                        push(ST_NOTFOUND, 8'd0, 32'd0, 1'b1);
                    else
                    begin
                        if (kind == KIND_KILL)
                            tbl_phase[slot] = 2'd0;
                        else
                        begin
                            // The sum saturates to the signed 16-bit range.
                            sum = int'(tbl_time[slot]) + int'(turns);
                            if (sum > 32767)
                                sum = 32767;
                            if (sum < -32768)
                                sum = -32768;
                            tbl_time[slot] = 16'(sum);
                        end
                        push(ST_OK, 8'd0, 32'd0, 1'b1);
                    end
                end
                KIND_RUN_DAEMONS:
                begin
                    foreach (tbl_phase[i])
                        if (tbl_phase[i] != 2'd0 && tbl_phase[i] == ph
                            && tbl_time[i] == DAEMON_TIME)
                        begin
                            push(ST_OK, tbl_action[i], tbl_arg[i], 1'b0);
                            n++;
                        end
                end
                KIND_RUN_FUSES:
                begin
                    foreach (tbl_phase[i])
                        if (tbl_phase[i] != 2'd0 && tbl_phase[i] == ph && tbl_time[i] > 0)
                        begin
                            tbl_time[i] = tbl_time[i] - 16'sd1;
                            if (tbl_time[i] == 0)
                            begin
                                tbl_phase[i] = 2'd0;
                                push(ST_OK, tbl_action[i], tbl_arg[i], 1'b0);
                                n++;
                            end
                        end
                end
                default:
                    push(ST_NONE, 8'd0, 32'd0, 1'b1);
            endcase
            if (kind == KIND_RUN_DAEMONS || kind == KIND_RUN_FUSES)
            begin
                if (n == 0)
                    push(ST_NONE, 8'd0, 32'd0, 1'b1);
                else
                    pending[pending.size() - 1].last = 1'b1;
            end
        endfunction

        // Compare one result transfer with the oldest expectation.
        function void check_result(logic [1:0] st, logic [7:0] id, logic [31:0] arg,
                                   logic lst);
            timer_result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result: status %0d id %0d arg %h", st, id, arg);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (id !== e.fired_id)
            begin
                $error("fired_id: expected %0d, got %0d", e.fired_id, id);
                errors++;
            end
            if (arg !== e.fired_arg)
            begin
                $error("fired_arg: expected %h, got %h", e.fired_arg, arg);
                errors++;
            end
            if (lst !== e.last)
            begin
                $error("last: expected %0d, got %0d", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    timer_table_board board;
    longint cycle_count;
    // Set once the random idling is switched off for the closing stretch.
    bit     quiet_end;
    // Set while the receiver is asked to hold off for a long stretch.
    bit     hold_sink;

    delayed_action_timer_table #(.SLOTS(NSLOTS)) DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        board = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 64'd0;
        s_axis_tuser = 3'd0;
        m_axis_tready = 1'b0;
        quiet_end = 1'b0;
        hold_sink = 1'b0;
        cycle_count = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
    end

    // The checker samples on the same edge at which the transfer happens.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8],
                               m_axis_tlast);
    end

    // Watchdog on the run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver: random stall bursts, stretches of steady acceptance, and a
    // long hold-off when requested so the table backs up into its input.
    initial
    begin : sink_proc
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (300)
                    @(posedge clk);
                hold_sink = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet_end && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (gap - 1)
                    @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offer one command and hold it until the block accepts it.
    task automatic send_command(logic [2:0] kind, logic [7:0] id, logic [31:0] arg,
                                logic [1:0] ph, logic signed [15:0] turns);
        int gap;
        if (!quiet_end && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {6'd0, turns, ph, arg, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        board.note_command(kind, id, arg, ph, turns);
    endtask

    // Random command, biased toward a table with live entries and real firings.
    task automatic send_random();
        int pick;
        logic [2:0] kind;
        logic signed [15:0] turns;
        pick = $urandom_range(0, 99);
        if (pick < 22)
            kind = KIND_START_FUSE;
        else if (pick < 36)
            kind = KIND_START_DAEMON;
        else if (pick < 48)
            kind = KIND_KILL;
        else if (pick < 58)
            kind = KIND_LENGTHEN;
        else if (pick < 70)
            kind = KIND_RUN_DAEMONS;
        else if (pick < 96)
            kind = KIND_RUN_FUSES;
        else
            kind = 3'($urandom_range(6, 7));
        case ($urandom_range(0, 5))
            0:       turns = 16'($urandom);
            1:       turns = -16'sd1;
            2:       turns = ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: turns = 16'($urandom_range(0, 6));
        endcase
        // Few distinct ids so that kill and lengthen mostly find their target.
        send_command(kind, 8'($urandom_range(0, 11)) | ($urandom_range(0, 9) == 0 ?
                     8'($urandom) : 8'd0), $urandom, 2'($urandom_range(0, 3)), turns);
    endtask

    initial
    begin : stim_proc
        int wait_count;
        @(posedge rst_n);
        @(posedge clk);
        // Directed part: every command, empty-table cases and field extremes.
        send_command(KIND_RUN_DAEMONS, 8'd0, 32'd0, 2'd1, 16'sd0);
        send_command(KIND_RUN_FUSES, 8'd0, 32'd0, 2'd2, 16'sd0);
        send_command(KIND_KILL, 8'd5, 32'd0, 2'd1, 16'sd0);
        send_command(KIND_LENGTHEN, 8'd5, 32'd0, 2'd1, 16'sd3);
        send_command(3'd6, 8'hff, 32'hffff_ffff, 2'd3, 16'shffff);
        send_command(3'd7, 8'd0, 32'd0, 2'd0, 16'sd0);
        send_command(KIND_START_DAEMON, 8'hff, 32'h8000_0000, 2'd3, 16'sd0);
        send_command(KIND_START_DAEMON, 8'd0, 32'h7fff_ffff, 2'd1, 16'sd0);
        // Phase zero start writes a slot that stays empty.
        send_command(KIND_START_DAEMON, 8'd9, 32'd1, 2'd0, 16'sd0);
        send_command(KIND_START_FUSE, 8'd1, 32'hdead_beef, 2'd2, 16'sd1);
        send_command(KIND_START_FUSE, 8'd2, 32'd0, 2'd2, 16'sh7fff);
        send_command(KIND_START_FUSE, 8'd3, 32'd33, 2'd2, 16'sh8000);
        send_command(KIND_START_FUSE, 8'd4, 32'd44, 2'd1, -16'sd1);
        send_command(KIND_START_FUSE, 8'd6, 32'd66, 2'd3, 16'sd0);
        send_command(KIND_RUN_DAEMONS, 8'd0, 32'd0, 2'd1, 16'sd0);
        send_command(KIND_RUN_DAEMONS, 8'd0, 32'd0, 2'd0, 16'sd0);
        send_command(KIND_RUN_FUSES, 8'd0, 32'd0, 2'd2, 16'sd0);
        send_command(KIND_RUN_FUSES, 8'd0, 32'd0, 2'd0, 16'sd0);
        // Saturation in both directions, and a daemon lengthened away.
        send_command(KIND_LENGTHEN, 8'd2, 32'd0, 2'd0, 16'sh7fff);
        send_command(KIND_LENGTHEN, 8'd3, 32'd0, 2'd0, 16'sh8000);
        send_command(KIND_LENGTHEN, 8'hff, 32'd0, 2'd0, 16'sd2);
        send_command(KIND_KILL, 8'd0, 32'd0, 2'd0, 16'sd0);
        send_command(KIND_RUN_DAEMONS, 8'd0, 32'd0, 2'd3, 16'sd0);
        // Fill the table completely, then overflow it.
        while (board.count_live() < NSLOTS)
            send_command(KIND_START_DAEMON, 8'($urandom_range(20, 40)), $urandom,
                         2'd1, 16'sd0);
        send_command(KIND_START_FUSE, 8'd7, 32'd7, 2'd1, 16'sd2);
        // A full table, mostly of phase-one daemons, gives a large burst of results,
        // with the receiver held off so the block backs up into its input.
        hold_sink = 1'b1;
        send_command(KIND_RUN_DAEMONS, 8'd0, 32'd0, 2'd1, 16'sd0);
        send_command(KIND_RUN_DAEMONS, 8'd0, 32'd0, 2'd1, 16'sd0);
        send_command(KIND_RUN_FUSES, 8'd0, 32'd0, 2'd1, 16'sd0);
        // Empty the table again before the random part.
        while (board.count_live() > 0)
            send_command(KIND_KILL, board.first_live_action(), 32'd0, 2'd0, 16'sd0);
        repeat (35)
            send_random();
        quiet_end = 1'b1;
        repeat (15)
            send_random();
        s_axis_tvalid <= 1'b0;
        wait_count = 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        while (wait_count < 3 * NSLOTS)
        begin
            @(posedge clk);
            wait_count++;
        end
        if (board.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/datt_pkg.sv
sv/datt_cell.sv
sv/datt_head.sv
sv/delayed_action_timer_table.sv
bench/tb_top.sv
